### src/f16fr_pkg.sv
// Shared types, constants and helpers for the Fletcher-16 frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package f16fr_pkg;

    localparam int MAX_PAYLOAD_BYTES = 7;

    localparam logic [7:0] SYNC_FIRST  = 8'hF0;
    localparam logic [7:0] SYNC_SECOND = 8'h0D;
    localparam logic [8:0] MOD_SUM     = 9'd255;

    localparam logic [2:0] LEN_CAL    = 3'd1;
    localparam logic [2:0] LEN_NOZZLE = 3'd5;
    localparam logic [2:0] LEN_COLOR  = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_CAL_TYPE    = 3'd0;
    localparam logic [2:0] REG_NOZZLE_TYPE = 3'd1;
    localparam logic [2:0] REG_COLOR_TYPE  = 3'd2;
    localparam logic [2:0] REG_START_CODE  = 3'd3;

    typedef enum logic [1:0] {
        KIND_CAL    = 2'd0,
        KIND_NOZZLE = 2'd1,
        KIND_COLOR  = 2'd2
    } t_kind;

    typedef enum logic [5:0] {
        ST_HUNT    = 6'b000001,
        ST_SYNC    = 6'b000010,
        ST_TYPE    = 6'b000100,
        ST_PAYLOAD = 6'b001000,
        ST_CHK_HI  = 6'b010000,
        ST_CHK_LO  = 6'b100000
    } t_state;

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] lo;
    } t_sum;

    function automatic logic [2:0] kind_length(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            KIND_CAL:    len = LEN_CAL;
            KIND_NOZZLE: len = LEN_NOZZLE;
            default:     len = LEN_COLOR;
        endcase
        return len;
    endfunction

    // a kind longer than the payload store is treated as unknown
    function automatic logic kind_fits(input logic [1:0] kind);
        return 32'(kind_length(kind)) <= 32'(MAX_PAYLOAD_BYTES);
    endfunction

endpackage

### src/f16fr_sum.sv
// Fletcher-16 step: folds one byte into both running sums, each mod 255.
// Depends on f16fr_pkg.
`timescale 1ns / 1ps

module f16fr_sum import f16fr_pkg::*; (
    input  t_sum       i_sum,
    input  logic       i_restart,
    input  logic [7:0] i_byte,
    output t_sum       o_sum
);

    t_sum       base;
    logic [8:0] lo_raw;
    logic [7:0] lo_new;
    logic [8:0] hi_raw;

    // both halves stay below 255, so one conditional subtract is enough
    always_comb begin
        base   = i_restart ? '0 : i_sum;
        lo_raw = {1'b0, base.lo} + {1'b0, i_byte};
        lo_new = (lo_raw >= MOD_SUM) ? 8'(lo_raw - MOD_SUM) : lo_raw[7:0];
        hi_raw = {1'b0, base.hi} + {1'b0, lo_new};
        o_sum.lo = lo_new;
        o_sum.hi = (hi_raw >= MOD_SUM) ? 8'(hi_raw - MOD_SUM) : hi_raw[7:0];
    end

endmodule

### src/fletcher16_frame_receiver.sv
// Fletcher-16 framed serial receiver, top level. Uses f16fr_pkg, f16fr_sum.
// Throughput: one byte word per cycle; the parse state steps once per accepted word.
// Latency: a frame's result is valid in the cycle after its low checksum word is taken.
// The result register parts the sides: input stalls only on a low checksum word
// while a previous result is still unread.
// Reset (synchronous, active low): hunting for sync, no result held, codes 1, 2, 3, 1.
`timescale 1ns / 1ps

module fletcher16_frame_receiver import f16fr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_msg_valid,
    input  logic        i_msg_ready,
    output logic [1:0]  o_msg_kind,
    output logic [55:0] o_payload_bits,
    output logic [2:0]  o_payload_count,
    output logic        o_checksum_ok,
    output logic        o_start_calibration
);

    logic [7:0]  r_cal_code, r_nozzle_code, r_color_code, r_start_code;
    t_state      r_state, n_state;
    logic [2:0]  r_left, n_left;
    t_sum        r_sum, n_sum;
    logic [1:0]  r_kind, n_kind;
    logic [55:0] r_payload, n_payload;
    logic [7:0]  r_chk_hi, n_chk_hi;
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [55:0] r_out_payload;
    logic [2:0]  r_out_count;
    logic        r_out_ok, r_out_start;

    logic        accept, sum_en, restart, type_hit, ok;
    logic [1:0]  type_kind;
    logic [2:0]  pos;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_code    <= 8'd1;
            r_nozzle_code <= 8'd2;
            r_color_code  <= 8'd3;
            r_start_code  <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CAL_TYPE:    r_cal_code    <= i_cfg_data;
                REG_NOZZLE_TYPE: r_nozzle_code <= i_cfg_data;
                REG_COLOR_TYPE:  r_color_code  <= i_cfg_data;
                REG_START_CODE:  r_start_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_rx_ready = !(r_state == ST_CHK_LO && r_out_valid && !i_msg_ready);
    assign accept     = i_rx_valid && o_rx_ready;

    f16fr_sum u_sum (
        .i_sum     (r_sum),
        .i_restart (restart),
        .i_byte    (i_rx_byte),
        .o_sum     (n_sum)
    );

    // type decode, calibration first
    always_comb begin
        type_hit  = 1'b1;
        type_kind = KIND_CAL;
        if (i_rx_byte == r_cal_code)         type_kind = KIND_CAL;
        else if (i_rx_byte == r_nozzle_code) type_kind = KIND_NOZZLE;
        else if (i_rx_byte == r_color_code)  type_kind = KIND_COLOR;
        else                                 type_hit  = 1'b0;
        if (!kind_fits(type_kind)) type_hit = 1'b0;
    end

    assign pos = kind_length(r_kind) - r_left;
    assign ok  = ({r_chk_hi, i_rx_byte} == {r_sum.hi, r_sum.lo});

    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_kind    = r_kind;
        n_payload = r_payload;
        n_chk_hi  = r_chk_hi;
        sum_en    = 1'b0;
        restart   = 1'b0;
        case (r_state)
            ST_HUNT: begin
                if (i_rx_byte == SYNC_FIRST) begin
                    restart = 1'b1;
                    sum_en  = 1'b1;
                    n_state = ST_SYNC;
                end
            end
            ST_SYNC: begin
                // a bad second sync word is dropped, not retried as a first
                if (i_rx_byte == SYNC_SECOND) begin
                    sum_en  = 1'b1;
                    n_state = ST_TYPE;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_TYPE: begin
                if (type_hit) begin
                    sum_en    = 1'b1;
                    n_kind    = type_kind;
                    n_left    = kind_length(type_kind);
                    n_payload = '0;
                    n_state   = ST_PAYLOAD;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_PAYLOAD: begin
                sum_en = 1'b1;
                for (int k = 0; k < MAX_PAYLOAD_BYTES; k++) begin
                    if (32'(pos) == k) n_payload[8*k +: 8] = i_rx_byte;
                end
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) n_state = ST_CHK_HI;
            end
            ST_CHK_HI: begin
                n_chk_hi = i_rx_byte;
                n_state  = ST_CHK_LO;
            end
            ST_CHK_LO: begin
                n_state = ST_HUNT;
                n_left  = '0;
            end
            default: begin
                n_state = ST_HUNT;
                n_left  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT;
            r_left    <= '0;
            r_sum     <= '0;
            r_kind    <= KIND_CAL;
            r_payload <= '0;
            r_chk_hi  <= '0;
        end else if (accept) begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_kind    <= n_kind;
            r_payload <= n_payload;
            r_chk_hi  <= n_chk_hi;
            if (sum_en) r_sum <= n_sum;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && r_state == ST_CHK_LO) begin
            r_out_valid <= 1'b1;
        end else if (i_msg_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_state == ST_CHK_LO) begin
            r_out_kind    <= r_kind;
            r_out_payload <= r_payload;
            r_out_count   <= kind_length(r_kind);
            r_out_ok      <= ok;
            r_out_start   <= ok && (r_kind == KIND_CAL) && (r_payload[7:0] == r_start_code);
        end
    end

    assign o_msg_valid         = r_out_valid;
    assign o_msg_kind          = r_out_kind;
    assign o_payload_bits      = r_out_payload;
    assign o_payload_count     = r_out_count;
    assign o_checksum_ok       = r_out_ok;
    assign o_start_calibration = r_out_start;

endmodule

### src/f16fr_checker.sv
// Port-level checks for the Fletcher-16 frame receiver, bound to the top level.
// Depends on f16fr_pkg and fletcher16_frame_receiver.
`timescale 1ns / 1ps

module f16fr_checker import f16fr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_msg_valid,
    input logic        i_msg_ready,
    input logic [1:0]  o_msg_kind,
    input logic [55:0] o_payload_bits,
    input logic [2:0]  o_payload_count,
    input logic        o_checksum_ok,
    input logic        o_start_calibration
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid && !i_msg_ready |=> o_msg_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid && !i_msg_ready |=> $stable(o_payload_bits) && $stable(o_msg_kind))
        else $error("stalled result word changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid |-> (o_msg_kind == KIND_CAL && o_payload_count == LEN_CAL)
                     || (o_msg_kind == KIND_NOZZLE && o_payload_count == LEN_NOZZLE)
                     || (o_msg_kind == KIND_COLOR && o_payload_count == LEN_COLOR))
        else $error("payload count does not match kind");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid && o_start_calibration |-> o_checksum_ok && o_msg_kind == KIND_CAL)
        else $error("start flag without good calibration frame");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid && o_msg_kind == KIND_CAL |-> o_payload_bits[55:8] == '0)
        else $error("unused payload bytes not zero");

endmodule

bind fletcher16_frame_receiver f16fr_checker u_f16fr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_msg_valid         (o_msg_valid),
    .i_msg_ready         (i_msg_ready),
    .o_msg_kind          (o_msg_kind),
    .o_payload_bits      (o_payload_bits),
    .o_payload_count     (o_payload_count),
    .o_checksum_ok       (o_checksum_ok),
    .o_start_calibration (o_start_calibration)
);
